// ===== rtl/core/iau_pkg.sv =====
// Shared types, constants and saturation helpers for the interval arithmetic unit.
// Used by iau_mul, iau_recip and interval_arithmetic_unit; depends on nothing.
`timescale 1ns / 1ps

package iau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int EXP_BITS  = 6;
  localparam int RCP_STEPS = 2 * FRAC_BITS + 1;
  localparam int RCP_CNT_W = $clog2(RCP_STEPS);
  localparam int POW_CNT_W = EXP_BITS - 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   wide_t;

  localparam word_t MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam wide_t WIDE_MAX = {2'b00, {(WORD_BITS-1){1'b1}}};
  localparam wide_t WIDE_MIN = {2'b11, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_POW, OP_DIST, OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_DIVZERO, ST_BADEXP, ST_SAT
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RCP_START, S_RCP_WAIT, S_MUL_ISSUE, S_MUL_WAIT,
    S_POW_CHECK, S_POW_ISSUE, S_POW_WAIT, S_DONE
  } state_t;

  // Saturated word plus the flag that says clamping happened
  typedef struct packed {
    word_t value;
    logic  sat;
  } sat_word_t;

  // Reciprocal unit response
  typedef struct packed {
    logic  done;
    logic  sat;
    word_t value;
  } rcp_rsp_t;

  // Clamp a one-bit-wider signed value into the word range
  function automatic sat_word_t clamp_wide(input wide_t v);
    sat_word_t r;
    r.sat   = 1'b0;
    r.value = v[WORD_BITS-1:0];
    if (v > WIDE_MAX) begin
      r.sat   = 1'b1;
      r.value = MAX_POS;
    end else if (v < WIDE_MIN) begin
      r.sat   = 1'b1;
      r.value = MIN_NEG;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/iau_mul.sv =====
// Shared fixed-point multiplier: registered signed product, floor shift, saturation.
// Depends on iau_pkg.
`timescale 1ns / 1ps

module iau_mul (
  input  logic                clk,
  input  iau_pkg::word_t      a,
  input  iau_pkg::word_t      b,
  output iau_pkg::sat_word_t  res
);

  localparam int PW = 2 * iau_pkg::WORD_BITS;
  localparam logic signed [PW-1:0] P_MAX =
    {{(iau_pkg::WORD_BITS+1){1'b0}}, {(iau_pkg::WORD_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN =
    {{(iau_pkg::WORD_BITS+1){1'b1}}, {(iau_pkg::WORD_BITS-1){1'b0}}};

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] shifted;

  // Register the full product
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  // Arithmetic shift rounds toward minus infinity; clamp to the word range
  always_comb begin
    shifted   = prod_r >>> iau_pkg::FRAC_BITS;
    res.sat   = 1'b0;
    res.value = shifted[iau_pkg::WORD_BITS-1:0];
    if (shifted > P_MAX) begin
      res.sat   = 1'b1;
      res.value = iau_pkg::MAX_POS;
    end else if (shifted < P_MIN) begin
      res.sat   = 1'b1;
      res.value = iau_pkg::MIN_NEG;
    end
  end

endmodule

// ===== rtl/core/iau_recip.sv =====
// Bit-serial reciprocal unit: floor(2^(2F) / x), one quotient bit per cycle.
// Depends on iau_pkg.
`timescale 1ns / 1ps

module iau_recip (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  iau_pkg::word_t     x,
  output iau_pkg::rcp_rsp_t  rsp
);

  localparam int W = iau_pkg::WORD_BITS;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [iau_pkg::RCP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]                  d_r, d_nxt;
  logic [W-1:0]                  rem_r, rem_nxt;
  logic [W:0]                    q_r, q_nxt;
  logic                          neg_r, neg_nxt;
  logic                          zero_r, zero_nxt;
  logic [W:0]                    trial;
  logic                          ge;
  logic [W+1:0]                  qc;
  logic [W+1:0]                  lim;
  logic [W-1:0]                  mag;
  logic                          over;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  // Load the divisor magnitude, then shift in one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    trial    = {rem_r, (cnt_r == '0)};
    ge       = trial >= {1'b0, d_r};
    if (start) begin
      neg_nxt  = x[W-1];
      d_nxt    = x[W-1] ? W'(-x) : W'(x);
      zero_nxt = (x == '0);
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = '0;
      busy_nxt = (x != '0);
      done_nxt = (x == '0);
    end else if (busy_r) begin
      rem_nxt = ge ? W'(trial - {1'b0, d_r}) : trial[W-1:0];
      q_nxt   = {q_r[W-1:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == iau_pkg::RCP_CNT_W'(iau_pkg::RCP_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Round a negative quotient toward minus infinity, then saturate
  always_comb begin
    qc   = {1'b0, q_r} + (W+2)'(neg_r && (rem_r != '0));
    lim  = neg_r ? (W+2)'(1) << (W - 1) : ((W+2)'(1) << (W - 1)) - 1'b1;
    over = qc > lim;
    mag  = over ? lim[W-1:0] : qc[W-1:0];
    rsp.done  = done_r;
    rsp.sat   = over || zero_r;
    rsp.value = zero_r ? iau_pkg::MAX_POS : (neg_r ? -mag : mag);
  end

endmodule

// ===== rtl/core/interval_arithmetic_unit.sv =====
// Top level of the interval arithmetic unit: stream ports, sequencer, result register.
// Depends on iau_pkg, iau_mul and iau_recip.
`timescale 1ns / 1ps
//
// Usage: one input beat carries an opcode (in_tuser) and two Q16.16 intervals
// plus an exponent (in_tdata). One output beat returns the result interval
// (out_tdata) and a status code (out_tuser). Every input beat yields exactly
// one output beat, in order.
// Add, subtract, negate, distance and error cases end at the decode step;
// multiply runs four bound products through the shared multiplier; divide
// takes two bit-serial reciprocal passes, then multiplies; power runs n-1
// products per bound (n up to 31), only the high one for even n across zero.
// One item is in work at a time: in_tready is high only while the sequencer
// is idle. The output register holds a finished result while the receiver
// stalls, and the next input beat is still accepted meanwhile; the sequencer
// waits at its last step until the output register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid.

module interval_arithmetic_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // a_low, a_high, b_low, b_high, exponent, zero pad
  input  logic [7:0]   in_tuser,   // opcode, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // res_low, res_high
  output logic [7:0]   out_tuser   // status, zero pad
);

  localparam int W = iau_pkg::WORD_BITS;
  localparam int E = iau_pkg::EXP_BITS;

  iau_pkg::state_t                state_r, state_nxt;
  iau_pkg::op_t                   op_r, op_nxt;
  iau_pkg::word_t                 al_r, al_nxt, ah_r, ah_nxt;
  iau_pkg::word_t                 bl_r, bl_nxt, bh_r, bh_nxt;
  logic signed [E-1:0]            exp_r, exp_nxt;
  iau_pkg::word_t                 lo_r, lo_nxt, hi_r, hi_nxt;
  iau_pkg::word_t                 p_r, p_nxt, rtmp_r, rtmp_nxt;
  logic                           flag_r, flag_nxt;
  iau_pkg::status_t               st_r, st_nxt;
  logic [1:0]                     k_r, k_nxt;
  logic                           rsel_r, rsel_nxt;
  logic                           pass_r, pass_nxt;
  logic [iau_pkg::POW_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           ovalid_r, ovalid_nxt;
  iau_pkg::word_t                 olo_r, olo_nxt, ohi_r, ohi_nxt;
  iau_pkg::status_t               ost_r, ost_nxt;

  iau_pkg::word_t     mul_a, mul_b;
  iau_pkg::sat_word_t mul_res;
  logic               rcp_start;
  iau_pkg::word_t     rcp_x;
  iau_pkg::rcp_rsp_t  rcp_rsp;

  iau_pkg::sat_word_t s_lo, s_hi;
  logic [W:0]         d1, d2, dmax;
  logic [W:0]         mag_al, mag_ah, m;

  iau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  iau_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rcp_start),
    .x     (rcp_x),
    .rsp   (rcp_rsp)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= iau_pkg::S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    al_r   <= al_nxt;
    ah_r   <= ah_nxt;
    bl_r   <= bl_nxt;
    bh_r   <= bh_nxt;
    exp_r  <= exp_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    p_r    <= p_nxt;
    rtmp_r <= rtmp_nxt;
    flag_r <= flag_nxt;
    st_r   <= st_nxt;
    k_r    <= k_nxt;
    rsel_r <= rsel_nxt;
    pass_r <= pass_nxt;
    cnt_r  <= cnt_nxt;
    olo_r  <= olo_nxt;
    ohi_r  <= ohi_nxt;
    ost_r  <= ost_nxt;
  end

  // Combinational results: sums, differences, negation, distance, power magnitude
  always_comb begin
    unique case (op_r)
      iau_pkg::OP_ADD: begin
        s_lo = iau_pkg::clamp_wide({al_r[W-1], al_r} + {bl_r[W-1], bl_r});
        s_hi = iau_pkg::clamp_wide({ah_r[W-1], ah_r} + {bh_r[W-1], bh_r});
      end
      iau_pkg::OP_SUB: begin
        s_lo = iau_pkg::clamp_wide({al_r[W-1], al_r} - {bh_r[W-1], bh_r});
        s_hi = iau_pkg::clamp_wide({ah_r[W-1], ah_r} - {bl_r[W-1], bl_r});
      end
      default: begin
        s_lo = iau_pkg::clamp_wide(-{ah_r[W-1], ah_r});
        s_hi = iau_pkg::clamp_wide(-{al_r[W-1], al_r});
      end
    endcase
    d1     = (al_r >= bl_r) ? ({al_r[W-1], al_r} - {bl_r[W-1], bl_r})
                            : ({bl_r[W-1], bl_r} - {al_r[W-1], al_r});
    d2     = (ah_r >= bh_r) ? ({ah_r[W-1], ah_r} - {bh_r[W-1], bh_r})
                            : ({bh_r[W-1], bh_r} - {ah_r[W-1], ah_r});
    dmax   = (d1 > d2) ? d1 : d2;
    mag_al = al_r[W-1] ? -{al_r[W-1], al_r} : {1'b0, al_r};
    mag_ah = ah_r[W-1] ? -{ah_r[W-1], ah_r} : {1'b0, ah_r};
    m      = (mag_al > mag_ah) ? mag_al : mag_ah;
  end

  // Shared multiplier operands
  always_comb begin
    if (state_r == iau_pkg::S_POW_ISSUE) begin
      mul_a = p_r;
      mul_b = pass_r ? ah_r : al_r;
    end else begin
      mul_a = k_r[1] ? ah_r : al_r;
      mul_b = k_r[0] ? bh_r : bl_r;
    end
    rcp_x = rsel_r ? bl_r : bh_r;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    al_nxt     = al_r;
    ah_nxt     = ah_r;
    bl_nxt     = bl_r;
    bh_nxt     = bh_r;
    exp_nxt    = exp_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    p_nxt      = p_r;
    rtmp_nxt   = rtmp_r;
    flag_nxt   = flag_r;
    st_nxt     = st_r;
    k_nxt      = k_r;
    rsel_nxt   = rsel_r;
    pass_nxt   = pass_r;
    cnt_nxt    = cnt_r;
    olo_nxt    = olo_r;
    ohi_nxt    = ohi_r;
    ost_nxt    = ost_r;
    ovalid_nxt = ovalid_r && !out_tready;
    rcp_start  = 1'b0;
    in_tready  = (state_r == iau_pkg::S_IDLE);

    unique case (state_r)
      // Take a beat and clear the working result
      iau_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = iau_pkg::op_t'(in_tuser[2:0]);
          al_nxt    = in_tdata[W-1:0];
          ah_nxt    = in_tdata[2*W-1:W];
          bl_nxt    = in_tdata[3*W-1:2*W];
          bh_nxt    = in_tdata[4*W-1:3*W];
          exp_nxt   = in_tdata[4*W+E-1:4*W];
          lo_nxt    = '0;
          hi_nxt    = '0;
          flag_nxt  = 1'b0;
          st_nxt    = iau_pkg::ST_OK;
          state_nxt = iau_pkg::S_DECODE;
        end
      end

      // Finish simple operations or start a multi-cycle sequence
      iau_pkg::S_DECODE: begin
        state_nxt = iau_pkg::S_DONE;
        unique case (op_r)
          iau_pkg::OP_ADD, iau_pkg::OP_SUB, iau_pkg::OP_NEG: begin
            lo_nxt   = s_lo.value;
            hi_nxt   = s_hi.value;
            flag_nxt = s_lo.sat || s_hi.sat;
          end
          iau_pkg::OP_MUL: begin
            k_nxt     = '0;
            state_nxt = iau_pkg::S_MUL_ISSUE;
          end
          iau_pkg::OP_DIV: begin
            if (!bh_r[W-1] && (bl_r[W-1] || bl_r == '0)) begin
              st_nxt = iau_pkg::ST_DIVZERO;
            end else begin
              rsel_nxt  = 1'b0;
              state_nxt = iau_pkg::S_RCP_START;
            end
          end
          iau_pkg::OP_POW: begin
            if (exp_r[E-1] || exp_r == '0) begin
              st_nxt = iau_pkg::ST_BADEXP;
            end else begin
              state_nxt = iau_pkg::S_POW_CHECK;
              cnt_nxt   = iau_pkg::POW_CNT_W'(1);
              priority if (al_r > 0 || exp_r[0]) begin
                pass_nxt = 1'b0;
                p_nxt    = al_r;
              end else if (ah_r[W-1]) begin
                pass_nxt = 1'b0;
                al_nxt   = ah_r;
                ah_nxt   = al_r;
                p_nxt    = ah_r;
              end else begin
                // Interval straddles zero with an even power: low bound is zero
                pass_nxt = 1'b1;
                lo_nxt   = '0;
                if (m > {1'b0, iau_pkg::MAX_POS}) begin
                  ah_nxt   = iau_pkg::MAX_POS;
                  p_nxt    = iau_pkg::MAX_POS;
                  flag_nxt = 1'b1;
                end else begin
                  ah_nxt = m[W-1:0];
                  p_nxt  = m[W-1:0];
                end
              end
            end
          end
          iau_pkg::OP_DIST: begin
            if (dmax > {1'b0, iau_pkg::MAX_POS}) begin
              lo_nxt   = iau_pkg::MAX_POS;
              flag_nxt = 1'b1;
            end else begin
              lo_nxt = dmax[W-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      // Reciprocal of the high divisor bound first, then the low one
      iau_pkg::S_RCP_START: begin
        rcp_start = 1'b1;
        state_nxt = iau_pkg::S_RCP_WAIT;
      end

      iau_pkg::S_RCP_WAIT: begin
        if (rcp_rsp.done) begin
          flag_nxt = flag_r || rcp_rsp.sat;
          if (!rsel_r) begin
            rtmp_nxt  = rcp_rsp.value;
            rsel_nxt  = 1'b1;
            state_nxt = iau_pkg::S_RCP_START;
          end else begin
            bl_nxt    = rtmp_r;
            bh_nxt    = rcp_rsp.value;
            k_nxt     = '0;
            state_nxt = iau_pkg::S_MUL_ISSUE;
          end
        end
      end

      // Four bound products through the shared multiplier, tracking min and max
      iau_pkg::S_MUL_ISSUE: begin
        state_nxt = iau_pkg::S_MUL_WAIT;
      end

      iau_pkg::S_MUL_WAIT: begin
        flag_nxt = flag_r || mul_res.sat;
        if (k_r == '0) begin
          lo_nxt = mul_res.value;
          hi_nxt = mul_res.value;
        end else begin
          if (mul_res.value < lo_r) begin
            lo_nxt = mul_res.value;
          end
          if (mul_res.value > hi_r) begin
            hi_nxt = mul_res.value;
          end
        end
        if (k_r == 2'd3) begin
          state_nxt = iau_pkg::S_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = iau_pkg::S_MUL_ISSUE;
        end
      end

      // Repeated products for the power, one pass per bound
      iau_pkg::S_POW_CHECK: begin
        if (cnt_r >= exp_r[E-2:0]) begin
          if (!pass_r) begin
            lo_nxt   = p_r;
            pass_nxt = 1'b1;
            p_nxt    = ah_r;
            cnt_nxt  = iau_pkg::POW_CNT_W'(1);
          end else begin
            hi_nxt    = p_r;
            state_nxt = iau_pkg::S_DONE;
          end
        end else begin
          state_nxt = iau_pkg::S_POW_ISSUE;
        end
      end

      iau_pkg::S_POW_ISSUE: begin
        state_nxt = iau_pkg::S_POW_WAIT;
      end

      iau_pkg::S_POW_WAIT: begin
        p_nxt     = mul_res.value;
        flag_nxt  = flag_r || mul_res.sat;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = iau_pkg::S_POW_CHECK;
      end

      // Hand the result to the output register once it is free
      iau_pkg::S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          if (st_r != iau_pkg::ST_OK) begin
            olo_nxt = '0;
            ohi_nxt = '0;
            ost_nxt = st_r;
          end else begin
            olo_nxt = lo_r;
            ohi_nxt = hi_r;
            ost_nxt = flag_r ? iau_pkg::ST_SAT : iau_pkg::ST_OK;
          end
          state_nxt = iau_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = iau_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {ohi_r, olo_r};
  assign out_tuser  = {6'b0, ost_r};

endmodule

// ===== test/iau_checker.sv =====
// Result checker for the interval arithmetic unit: predicts each result from the input beats.
// Depends on iau_pkg; instantiated by tb_top beside the unit.
`timescale 1ns / 1ps

module iau_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,   // a_low, a_high, b_low, b_high, exponent, zero pad
  input  logic [7:0]   in_tuser,   // opcode, zero pad
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,  // res_low, res_high
  input  logic [7:0]   out_tuser,  // status, zero pad
  output int           fail_count,
  output int           pending
);

  typedef logic signed [127:0] big_t;

  typedef struct {
    iau_pkg::word_t   lo;
    iau_pkg::word_t   hi;
    iau_pkg::status_t st;
  } interval_res_t;

  interval_res_t result_fifo[$];

  // Clamp an exact value into the word range and note any clamping
  function automatic iau_pkg::word_t clamp_big(input big_t v, inout bit sat);
    if (v > big_t'(iau_pkg::MAX_POS)) begin
      sat = 1'b1;
      return iau_pkg::MAX_POS;
    end
    if (v < big_t'(iau_pkg::MIN_NEG)) begin
      sat = 1'b1;
      return iau_pkg::MIN_NEG;
    end
    return iau_pkg::word_t'(v[iau_pkg::WORD_BITS-1:0]);
  endfunction

  // Floor-rounded fixed-point product
  function automatic iau_pkg::word_t fx_product(input iau_pkg::word_t x,
                                                input iau_pkg::word_t y, inout bit sat);
    big_t px, py, p;
    px = x;
    py = y;
    p  = (px * py) >>> iau_pkg::FRAC_BITS;
    return clamp_big(p, sat);
  endfunction

  // Floor of 2^(2F)/x, saturating on zero
  function automatic iau_pkg::word_t fx_inverse(input iau_pkg::word_t x, inout bit sat);
    big_t d, q, r, v;
    if (x == 0) begin
      sat = 1'b1;
      return iau_pkg::MAX_POS;
    end
    d = x;
    if (d < 0) d = -d;
    q = (big_t'(1) <<< (2 * iau_pkg::FRAC_BITS)) / d;
    r = (big_t'(1) <<< (2 * iau_pkg::FRAC_BITS)) % d;
    if (x < 0) v = -(q + ((r != 0) ? 1 : 0));
    else v = q;
    return clamp_big(v, sat);
  endfunction

  function automatic iau_pkg::word_t fx_power(input iau_pkg::word_t x, input int n,
                                              inout bit sat);
    iau_pkg::word_t p;
    p = x;
    for (int k = 1; k < n; k++) p = fx_product(p, x, sat);
    return p;
  endfunction

  // Min and max of the four bound products
  function automatic void span_product(input iau_pkg::word_t al, ah, bl, bh,
                                       output iau_pkg::word_t lo, hi, inout bit sat);
    iau_pkg::word_t p[4];
    p[0] = fx_product(al, bl, sat);
    p[1] = fx_product(al, bh, sat);
    p[2] = fx_product(ah, bl, sat);
    p[3] = fx_product(ah, bh, sat);
    lo = p[0];
    hi = p[0];
    for (int i = 1; i < 4; i++) begin
      if (p[i] < lo) lo = p[i];
      if (p[i] > hi) hi = p[i];
    end
  endfunction

  function automatic interval_res_t predict_interval(input logic [135:0] d, input logic [7:0] u);
    interval_res_t r;
    iau_pkg::word_t al, ah, bl, bh, rl, rh;
    big_t d1, d2, m1, m2;
    int n;
    bit sat;
    al  = d[31:0];
    ah  = d[63:32];
    bl  = d[95:64];
    bh  = d[127:96];
    n   = $signed(d[133:128]);
    sat = 1'b0;
    r.lo = '0;
    r.hi = '0;
    r.st = iau_pkg::ST_OK;
    case (iau_pkg::op_t'(u[2:0]))
      iau_pkg::OP_ADD: begin
        r.lo = clamp_big(big_t'(al) + big_t'(bl), sat);
        r.hi = clamp_big(big_t'(ah) + big_t'(bh), sat);
      end
      iau_pkg::OP_SUB: begin
        r.lo = clamp_big(big_t'(al) - big_t'(bh), sat);
        r.hi = clamp_big(big_t'(ah) - big_t'(bl), sat);
      end
      iau_pkg::OP_MUL: span_product(al, ah, bl, bh, r.lo, r.hi, sat);
      iau_pkg::OP_DIV: begin
        if (bh >= 0 && bl <= 0) begin
          r.st = iau_pkg::ST_DIVZERO;
        end else begin
          rl = fx_inverse(bh, sat);
          rh = fx_inverse(bl, sat);
          span_product(al, ah, rl, rh, r.lo, r.hi, sat);
        end
      end
      iau_pkg::OP_NEG: begin
        r.lo = clamp_big(-big_t'(ah), sat);
        r.hi = clamp_big(-big_t'(al), sat);
      end
      iau_pkg::OP_POW: begin
        if (n <= 0) begin
          r.st = iau_pkg::ST_BADEXP;
        end else if (al > 0 || n[0]) begin
          r.lo = fx_power(al, n, sat);
          r.hi = fx_power(ah, n, sat);
        end else if (ah < 0) begin
          r.lo = fx_power(ah, n, sat);
          r.hi = fx_power(al, n, sat);
        end else begin
          m1 = al;
          m2 = ah;
          if (m1 < 0) m1 = -m1;
          if (m2 < 0) m2 = -m2;
          r.hi = fx_power(clamp_big((m1 > m2) ? m1 : m2, sat), n, sat);
        end
      end
      iau_pkg::OP_DIST: begin
        d1 = big_t'(al) - big_t'(bl);
        d2 = big_t'(ah) - big_t'(bh);
        if (d1 < 0) d1 = -d1;
        if (d2 < 0) d2 = -d2;
        r.lo = clamp_big((d1 > d2) ? d1 : d2, sat);
      end
      default: ;
    endcase
    if (r.st != iau_pkg::ST_OK) begin
      r.lo = '0;
      r.hi = '0;
    end else if (sat) begin
      r.st = iau_pkg::ST_SAT;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, want);
    $display("MISMATCH %0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    interval_res_t want;
    if (rst_n && in_tvalid && in_tready)
      result_fifo.push_back(predict_interval(in_tdata, in_tuser));
    if (rst_n && out_tvalid && out_tready) begin
      if (result_fifo.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 64'h0);
      end else begin
        want = result_fifo.pop_front();
        if (out_tdata[31:0] !== want.lo)
          report_mismatch("res_low", {32'b0, out_tdata[31:0]}, {32'b0, want.lo});
        if (out_tdata[63:32] !== want.hi)
          report_mismatch("res_high", {32'b0, out_tdata[63:32]}, {32'b0, want.hi});
        if (out_tuser !== {6'b0, want.st})
          report_mismatch("status", {56'b0, out_tuser}, {62'b0, want.st});
      end
    end
    pending = result_fifo.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the interval arithmetic unit: clock, reset, stimulus and verdict.
// Depends on iau_pkg, interval_arithmetic_unit and iau_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 1750;
  localparam int STALL_LIMIT  = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // a_low, a_high, b_low, b_high, exponent, zero pad
  logic [7:0]   in_tuser;   // opcode, zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // res_low, res_high
  logic [7:0]   out_tuser;  // status, zero pad

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_cycles;
  int quiet_cycles;

  interval_arithmetic_unit u_top (.*);

  iau_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Count cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("interval_arithmetic_unit verification failed");
      $finish;
    end
  end

  // Receiver: long hold-off when asked, else random stalls
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        out_tready = 1'b0;
        holdoff_cycles--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic [2:0] op, input iau_pkg::word_t al, ah, bl, bh,
                           input logic [5:0] ex);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = {5'b0, op};
    in_tdata  = {2'b0, ex, bh, bl, ah, al};
    do begin
      #1;
      taken = in_tready;
      @(posedge clk);
      @(negedge clk);
    end while (!taken);
    in_tvalid = 1'b0;
  endtask

  function automatic iau_pkg::word_t pick_bound();
    case ($urandom_range(3))
      0: return $urandom();
      1: return iau_pkg::word_t'($signed($urandom_range(1 << 19)) - (1 << 18));
      2: return iau_pkg::word_t'($signed($urandom_range(4)) - 2) <<< iau_pkg::FRAC_BITS;
      default: return ($urandom_range(1)) ? iau_pkg::MAX_POS - $urandom_range(3)
                                          : iau_pkg::MIN_NEG + $urandom_range(3);
    endcase
  endfunction

  task automatic send_random();
    logic [5:0]     ex;
    iau_pkg::word_t al, ah, bl, bh;
    ex = ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(6, 1));
    al = pick_bound();
    ah = pick_bound();
    // Mostly well-ordered intervals, some inverted
    if ($urandom_range(4) != 0 && al > ah) begin
      bl = al; al = ah; ah = bl;
    end
    bl = pick_bound();
    bh = pick_bound();
    if ($urandom_range(4) != 0 && bl > bh) begin
      {bl, bh} = {bh, bl};
    end
    send_beat(3'($urandom_range(7)), al, ah, bl, bh, ex);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every operation, each special case
    send_beat(iau_pkg::OP_ADD, iau_pkg::MAX_POS, iau_pkg::MAX_POS, iau_pkg::MAX_POS, 1, 6'd0);
    send_beat(iau_pkg::OP_ADD, iau_pkg::MIN_NEG, 0, -1, 0, 6'd0);
    send_beat(iau_pkg::OP_SUB, iau_pkg::MIN_NEG, iau_pkg::MAX_POS, 1, -1, 6'd0);
    send_beat(iau_pkg::OP_MUL, iau_pkg::MIN_NEG, iau_pkg::MAX_POS, iau_pkg::MIN_NEG,
              iau_pkg::MAX_POS, 6'd0);
    send_beat(iau_pkg::OP_MUL, -3, 5, 32'h0000_8000, -32'h0001_8000, 6'd0);
    send_beat(iau_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, -1, 1, 6'd0);
    send_beat(iau_pkg::OP_DIV, 1, 2, 0, 5, 6'd0);
    send_beat(iau_pkg::OP_DIV, -7, 9, 0, -1, 6'd0);
    send_beat(iau_pkg::OP_DIV, iau_pkg::MIN_NEG, iau_pkg::MAX_POS, 1, iau_pkg::MAX_POS, 6'd0);
    send_beat(iau_pkg::OP_DIV, 32'h0003_0000, -32'h0001_0000, -3, iau_pkg::MIN_NEG, 6'd0);
    send_beat(iau_pkg::OP_NEG, iau_pkg::MIN_NEG, iau_pkg::MAX_POS, 0, 0, 6'd0);
    send_beat(iau_pkg::OP_POW, 32'h0001_0000, 32'h0002_0000, 0, 0, 6'd0);
    send_beat(iau_pkg::OP_POW, 32'h0001_0000, 32'h0002_0000, 0, 0, 6'b111111);
    send_beat(iau_pkg::OP_POW, 32'h0001_0000, 32'h0001_1000, 0, 0, 6'd31);
    send_beat(iau_pkg::OP_POW, -32'h0002_0000, 32'h0001_0000, 0, 0, 6'd2);
    send_beat(iau_pkg::OP_POW, -32'h0003_0000, -32'h0001_0000, 0, 0, 6'd4);
    send_beat(iau_pkg::OP_POW, iau_pkg::MIN_NEG, 5, 0, 0, 6'd2);
    send_beat(iau_pkg::OP_POW, iau_pkg::MIN_NEG, iau_pkg::MAX_POS, 0, 0, 6'd3);
    send_beat(iau_pkg::OP_POW, 5, 3, 0, 0, 6'b100000);
    send_beat(iau_pkg::OP_DIST, iau_pkg::MIN_NEG, 0, iau_pkg::MAX_POS, 7, 6'd0);
    send_beat(iau_pkg::OP_DIST, 3, iau_pkg::MIN_NEG, 9, iau_pkg::MAX_POS, 6'd0);
    send_beat(iau_pkg::OP_NONE, iau_pkg::MAX_POS, iau_pkg::MIN_NEG, 1, 2, 6'b111111);
    send_beat(iau_pkg::OP_SUB, 32'h0005_0000, 32'h0001_0000, 4, 2, 6'd0);

    // Random phases: free flow (with one long hold-off), sender idle,
    // receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 72 : (phase == 3) ? 27 : 0;
      recv_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 27 : 0;
      if (phase == 0) holdoff_cycles = 600;
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_random();
    end

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("interval_arithmetic_unit verification clean");
    end else begin
      $display("interval_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule
